// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while the reset is released.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while the reset is released.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/e321_pkg.sv
// Types and constants for the 3-2-1 Euler angle rotation matrix block.
// No dependencies.
`default_nettype none

package e321_pkg;

    typedef logic signed [15:0] t_angle;
    typedef logic signed [15:0] t_coef;

    typedef struct packed {
        logic   req_type;
        t_angle roll_angle;
        t_angle pitch_angle;
        t_angle yaw_angle;
    } t_e321_in;

    typedef struct packed {
        t_coef elem_r0_c0;
        t_coef elem_r0_c1;
        t_coef elem_r0_c2;
        t_coef elem_r1_c0;
        t_coef elem_r1_c1;
        t_coef elem_r1_c2;
        t_coef elem_r2_c0;
        t_coef elem_r2_c1;
        t_coef elem_r2_c2;
    } t_e321_out;

    // Working precision of the trig values and products (Q30).
    localparam int WORK_FRAC = 30;

    // CORDIC start value of x: gain compensation with 32 fraction bits.
    localparam logic [31:0] CORDIC_GAIN = 32'h9B74_EDA8;

    // atan(2^-i) with one full turn equal to 2^32.
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2E, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
        32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051,
        32'h0000_0028, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
        32'h0000_0002, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000
    };

endpackage

`default_nettype wire

// File: rtl/euler_321_rotation_matrix.sv
// 3-2-1 Euler angles to direction cosine matrix, fully pipelined.
// Depends on e321_pkg.
//
//  Channel | Signals                      | Direction | Payload
//  --------+------------------------------+-----------+-----------------------
//  input   | i_valid, o_stall, i_data     | in        | t_e321_in (angles)
//  output  | o_valid, i_stall, o_data     | out       | t_e321_out (matrix)
//
// One transaction enters per cycle while the output does not stall; data runs
// through one CORDIC stage per register, then two multiply levels with rounding.
// The synchronous reset clears every valid bit of the pipeline.
// A stall with a full output register freezes every stage, empty ones too,
// so nothing is lost or repeated.
`default_nettype none

module euler_321_rotation_matrix #(
    parameter int ANGLE_BITS     = 16,
    parameter int COEF_FRAC_BITS = 14,
    parameter int TRIG_STAGES    = 16
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_stall,
    input  wire e321_pkg::t_e321_in   i_data,
    output logic                      o_valid,
    input  wire                       i_stall,
    output e321_pkg::t_e321_out       o_data
);
    import e321_pkg::*;

    localparam int XW = 35;
    localparam int ZW = 34;
    localparam int MW = 34;
    localparam logic [31:0] ANG_MASK = (ANGLE_BITS >= 32) ? 32'hFFFF_FFFF
                                       : 32'((64'd1 << ANGLE_BITS) - 64'd1);
    localparam int ANG_SHIFT = (32 - ANGLE_BITS) % 32;
    localparam int OUT_SH    = WORK_FRAC - COEF_FRAC_BITS;
    localparam logic signed [MW-1:0] OUT_HALF =
        (OUT_SH > 0) ? MW'(64'd1 << (OUT_SH - 1)) : '0;
    localparam logic signed [MW-1:0] OUT_LIM  = MW'(64'd1 << COEF_FRAC_BITS);
    localparam logic signed [XW-1:0] TRIG_LIM = XW'(64'd1 << WORK_FRAC);
    localparam logic signed [63:0]   PROD_HALF = 64'sd1 <<< (WORK_FRAC - 1);

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // ---------------- Phase folding ----------------
    logic [2:0][15:0]         in_ang;
    logic signed [XW-1:0]     n_x0;
    logic signed [ZW-1:0]     n_z0 [3];
    logic [2:0]               n_neg0;

    assign in_ang[0] = i_data.roll_angle;
    assign in_ang[1] = i_data.pitch_angle;
    assign in_ang[2] = i_data.yaw_angle;
    assign n_x0      = XW'({1'b0, CORDIC_GAIN});

    always_comb begin
        logic [31:0] ph;
        for (int a = 0; a < 3; a++) begin
            ph = 32'(({16'd0, in_ang[a]} & ANG_MASK) << ANG_SHIFT);
            // Second and third quadrants are turned by pi; results negate.
            n_neg0[a] = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
            if (n_neg0[a]) begin
                ph[31] = ~ph[31];
            end
            n_z0[a] = {{(ZW - 32){ph[31]}}, ph};
        end
    end

    // ---------------- CORDIC stages ----------------
    logic signed [XW-1:0] r_cx [TRIG_STAGES+1][3];
    logic signed [XW-1:0] r_cy [TRIG_STAGES+1][3];
    logic signed [ZW-1:0] r_cz [TRIG_STAGES+1][3];
    logic [2:0]           r_cneg [TRIG_STAGES+1];
    logic                 r_creq [TRIG_STAGES+1];
    logic                 r_cv   [TRIG_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (en) begin
            r_cv[0] <= i_valid;
        end
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                r_cx[0][a] <= n_x0;
                r_cy[0][a] <= '0;
                r_cz[0][a] <= n_z0[a];
            end
            r_cneg[0] <= n_neg0;
            r_creq[0] <= i_data.req_type;
        end
    end

    for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[g+1] <= 1'b0;
            end else if (en) begin
                r_cv[g+1] <= r_cv[g];
            end
            if (en) begin
                for (int a = 0; a < 3; a++) begin
                    if (!r_cz[g][a][ZW-1]) begin
                        r_cx[g+1][a] <= r_cx[g][a] - (r_cy[g][a] >>> g);
                        r_cy[g+1][a] <= r_cy[g][a] + (r_cx[g][a] >>> g);
                        r_cz[g+1][a] <= r_cz[g][a] - $signed({2'b00, ATAN_TAB[g]});
                    end else begin
                        r_cx[g+1][a] <= r_cx[g][a] + (r_cy[g][a] >>> g);
                        r_cy[g+1][a] <= r_cy[g][a] - (r_cx[g][a] >>> g);
                        r_cz[g+1][a] <= r_cz[g][a] + $signed({2'b00, ATAN_TAB[g]});
                    end
                end
                r_cneg[g+1] <= r_cneg[g];
                r_creq[g+1] <= r_creq[g];
            end
        end
    end

    // ---------------- Round to Q30 ----------------
    logic signed [31:0] n_s [3];
    logic signed [31:0] n_c [3];
    logic signed [31:0] r_s [3];
    logic signed [31:0] r_c [3];
    logic               r_tv, r_treq;

    always_comb begin
        logic signed [XW-1:0] xr;
        logic signed [XW-1:0] yr;
        for (int a = 0; a < 3; a++) begin
            xr = (r_cx[TRIG_STAGES][a] + XW'(2)) >>> 2;
            yr = (r_cy[TRIG_STAGES][a] + XW'(2)) >>> 2;
            if (xr > TRIG_LIM) begin
                xr = TRIG_LIM;
            end else if (xr < -TRIG_LIM) begin
                xr = -TRIG_LIM;
            end
            if (yr > TRIG_LIM) begin
                yr = TRIG_LIM;
            end else if (yr < -TRIG_LIM) begin
                yr = -TRIG_LIM;
            end
            if (r_cneg[TRIG_STAGES][a]) begin
                xr = -xr;
                yr = -yr;
            end
            n_c[a] = xr[31:0];
            n_s[a] = yr[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= 1'b0;
        end else if (en) begin
            r_tv <= r_cv[TRIG_STAGES];
        end
        if (en) begin
            r_s    <= n_s;
            r_c    <= n_c;
            r_treq <= r_creq[TRIG_STAGES];
        end
    end

    // ---------------- First product level ----------------
    // 0 sph*sth, 1 cph*sth, 2 cth*cps, 3 cth*sps, 4 cph*sps,
    // 5 cph*cps, 6 sph*cth, 7 sph*sps, 8 sph*cps, 9 cph*cth.
    logic signed [63:0] r_p1 [10];
    logic signed [31:0] r_p1_sth, r_p1_sps, r_p1_cps;
    logic               r_p1v, r_p1req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1v <= 1'b0;
        end else if (en) begin
            r_p1v <= r_tv;
        end
        if (en) begin
            r_p1[0]  <= r_s[0] * r_s[1];
            r_p1[1]  <= r_c[0] * r_s[1];
            r_p1[2]  <= r_c[1] * r_c[2];
            r_p1[3]  <= r_c[1] * r_s[2];
            r_p1[4]  <= r_c[0] * r_s[2];
            r_p1[5]  <= r_c[0] * r_c[2];
            r_p1[6]  <= r_s[0] * r_c[1];
            r_p1[7]  <= r_s[0] * r_s[2];
            r_p1[8]  <= r_s[0] * r_c[2];
            r_p1[9]  <= r_c[0] * r_c[1];
            r_p1_sth <= r_s[1];
            r_p1_sps <= r_s[2];
            r_p1_cps <= r_c[2];
            r_p1req  <= r_treq;
        end
    end

    logic signed [31:0] r_q1 [10];
    logic signed [31:0] r_q1_sth, r_q1_sps, r_q1_cps;
    logic               r_q1v, r_q1req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1v <= 1'b0;
        end else if (en) begin
            r_q1v <= r_p1v;
        end
        if (en) begin
            for (int k = 0; k < 10; k++) begin
                r_q1[k] <= 32'((r_p1[k] + PROD_HALF) >>> WORK_FRAC);
            end
            r_q1_sth <= r_p1_sth;
            r_q1_sps <= r_p1_sps;
            r_q1_cps <= r_p1_cps;
            r_q1req  <= r_p1req;
        end
    end

    // ---------------- Second product level ----------------
    // 0 spst*cps, 1 spst*sps, 2 cpst*cps, 3 cpst*sps.
    logic signed [63:0] r_p2 [4];
    logic signed [31:0] r_p2_q [2:9];
    logic signed [31:0] r_p2_sth;
    logic               r_p2v, r_p2req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2v <= 1'b0;
        end else if (en) begin
            r_p2v <= r_q1v;
        end
        if (en) begin
            r_p2[0] <= r_q1[0] * r_q1_cps;
            r_p2[1] <= r_q1[0] * r_q1_sps;
            r_p2[2] <= r_q1[1] * r_q1_cps;
            r_p2[3] <= r_q1[1] * r_q1_sps;
            for (int k = 2; k < 10; k++) begin
                r_p2_q[k] <= r_q1[k];
            end
            r_p2_sth <= r_q1_sth;
            r_p2req  <= r_q1req;
        end
    end

    logic signed [31:0] r_q2 [4];
    logic signed [31:0] r_q2_q [2:9];
    logic signed [31:0] r_q2_sth;
    logic               r_q2v, r_q2req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q2v <= 1'b0;
        end else if (en) begin
            r_q2v <= r_p2v;
        end
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_q2[k] <= 32'((r_p2[k] + PROD_HALF) >>> WORK_FRAC);
            end
            r_q2_q   <= r_p2_q;
            r_q2_sth <= r_p2_sth;
            r_q2req  <= r_p2req;
        end
    end

    // ---------------- Matrix sums ----------------
    logic signed [MW-1:0] r_m [9];
    logic                 r_mv, r_mreq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (en) begin
            r_mv <= r_q2v;
        end
        if (en) begin
            r_m[0] <= MW'(r_q2_q[2]);
            r_m[1] <= MW'(r_q2_q[3]);
            r_m[2] <= -MW'(r_q2_sth);
            r_m[3] <= MW'(r_q2[0]) - MW'(r_q2_q[4]);
            r_m[4] <= MW'(r_q2[1]) + MW'(r_q2_q[5]);
            r_m[5] <= MW'(r_q2_q[6]);
            r_m[6] <= MW'(r_q2[2]) + MW'(r_q2_q[7]);
            r_m[7] <= MW'(r_q2[3]) - MW'(r_q2_q[8]);
            r_m[8] <= MW'(r_q2_q[9]);
            r_mreq <= r_q2req;
        end
    end

    // ---------------- Output rounding and transpose ----------------
    logic [8:0][15:0] n_e;

    always_comb begin
        logic signed [MW-1:0] v;
        logic [3:0]           src;
        for (int k = 0; k < 9; k++) begin
            src = r_mreq ? 4'((k % 3) * 3 + (k / 3)) : 4'(k);
            v   = (r_m[src] + OUT_HALF) >>> OUT_SH;
            if (v > OUT_LIM) begin
                v = OUT_LIM;
            end else if (v < -OUT_LIM) begin
                v = -OUT_LIM;
            end
            n_e[k] = v[15:0];
        end
    end

    logic r_ov;
    assign o_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_mv;
        end
        if (en) begin
            o_data.elem_r0_c0 <= n_e[0];
            o_data.elem_r0_c1 <= n_e[1];
            o_data.elem_r0_c2 <= n_e[2];
            o_data.elem_r1_c0 <= n_e[3];
            o_data.elem_r1_c1 <= n_e[4];
            o_data.elem_r1_c2 <= n_e[5];
            o_data.elem_r2_c0 <= n_e[6];
            o_data.elem_r2_c1 <= n_e[7];
            o_data.elem_r2_c2 <= n_e[8];
        end
    end

endmodule

`default_nettype wire

// File: rtl/e321_checker.sv
// Port-level checks for euler_321_rotation_matrix, bound to the top level.
// Depends on e321_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module e321_port_checks (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       i_valid,
    input wire                       o_stall,
    input wire e321_pkg::t_e321_in   i_data,
    input wire                       o_valid,
    input wire                       i_stall,
    input wire e321_pkg::t_e321_out  o_data
);
    import e321_pkg::*;

    // A waiting result stays and keeps its value.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data), "output transaction changed while stalled")
    // The input side only stalls when a full output register is held.
    `ASSERT_IMPLY(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stalled without a held output")
    // Reset leaves no result behind.
    `ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !o_valid, "output valid right after reset")

endmodule

bind euler_321_rotation_matrix e321_port_checks u_e321_port_checks (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

`default_nettype wire
